>>> sv/mtpc_pkg.sv
// Shared types, codes and the pattern generator step for the memory test
// pattern checker. No dependencies; used by every module of the block.
package mtpc_pkg;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 32;
    localparam int POS_W     = 23;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_WORDS = 4194304;

    localparam logic [DATA_W-1:0] SEED_RESET  = 32'h5A69_8421;
    localparam logic [ADDR_W-1:0] BASE_RESET  = 32'h7000_0000;
    localparam logic [POS_W-1:0]  COUNT_RESET = 23'd4194304;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE   = 2'd0,
        KIND_CHECK   = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_WRITE    = 2'd0,
        ST_MATCH    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 2'd0,
        REG_SEED  = 2'd1,
        REG_BASE  = 2'd2,
        REG_COUNT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] seed;
        logic [ADDR_W-1:0] base_address;
        logic [POS_W-1:0]  word_count;
    } cfg_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data_word;
        logic [DATA_W-1:0] actual_word;
        logic              last;
    } result_t;

    // Next word of the sequence: three xorshift32 rounds, or hold in fixed mode.
    // Each round is a fixed xor network, so the whole step is shallow logic.
    function automatic logic [DATA_W-1:0] advance_word(input logic mode,
                                                       input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] v;
        v = x;
        if (mode)
        begin
            for (int r = 0; r < 3; r++)
            begin
                v = v ^ (v << 13);
                v = v ^ (v >> 17);
                v = v ^ (v << 5);
            end
        end
        return v;
    endfunction

    // Word count clamped to MAX_WORDS.
    function automatic logic [POS_W-1:0] effective_count(input logic [POS_W-1:0] wc);
        logic [31:0] wide;
        wide = 32'(wc);
        if (wide > 32'(MAX_WORDS))
            return POS_W'(MAX_WORDS);
        return wc;
    endfunction

endpackage

>>> sv/mtpc_cfg_regs.sv
// Configuration register file of the memory test pattern checker.
// Depends on mtpc_pkg.
module mtpc_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mtpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtpc_pkg::DATA_W-1:0]         cfg_data,
    output mtpc_pkg::cfg_t                      cfg
);

    logic                              mode_reg;
    logic [mtpc_pkg::DATA_W-1:0]       seed_reg;
    logic [mtpc_pkg::ADDR_W-1:0]       base_reg;
    logic [mtpc_pkg::POS_W-1:0]        count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            seed_reg  <= mtpc_pkg::SEED_RESET;
            base_reg  <= mtpc_pkg::BASE_RESET;
            count_reg <= mtpc_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mtpc_pkg::REG_MODE:  mode_reg  <= cfg_data[0];
                mtpc_pkg::REG_SEED:  seed_reg  <= cfg_data;
                mtpc_pkg::REG_BASE:  base_reg  <= cfg_data[mtpc_pkg::ADDR_W-1:0];
                mtpc_pkg::REG_COUNT: count_reg <= cfg_data[mtpc_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.mode         = mode_reg;
    assign cfg.seed         = seed_reg;
    assign cfg.base_address = base_reg;
    assign cfg.word_count   = count_reg;

endmodule

>>> sv/mtpc_engine.sv
// Test state (write/check positions and generators, failure latch) and the
// single-pass logic that turns one item into its result. Depends on mtpc_pkg.
module mtpc_engine
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [mtpc_pkg::KIND_W-1:0]       kind,
    input  logic [mtpc_pkg::DATA_W-1:0]       read_data,
    input  mtpc_pkg::cfg_t                    cfg,
    output mtpc_pkg::result_t                 res
);

    logic [mtpc_pkg::POS_W-1:0]  wpos_reg, wpos_next;
    logic [mtpc_pkg::POS_W-1:0]  cpos_reg, cpos_next;
    logic [mtpc_pkg::DATA_W-1:0] wgen_reg, wgen_next;
    logic [mtpc_pkg::DATA_W-1:0] cgen_reg, cgen_next;
    logic                        failed_reg, failed_next;
    logic [mtpc_pkg::POS_W-1:0]  count;

    assign count = mtpc_pkg::effective_count(cfg.word_count);

    always_comb
    begin
        wpos_next       = wpos_reg;
        cpos_next       = cpos_reg;
        wgen_next       = wgen_reg;
        cgen_next       = cgen_reg;
        failed_next     = failed_reg;
        res.status      = mtpc_pkg::ST_IGNORED;
        res.address     = '0;
        res.data_word   = '0;
        res.actual_word = '0;
        res.last        = 1'b0;
        case (kind)
            mtpc_pkg::KIND_RESTART:
            begin
                wpos_next   = '0;
                cpos_next   = '0;
                wgen_next   = cfg.seed;
                cgen_next   = cfg.seed;
                failed_next = 1'b0;
            end
            mtpc_pkg::KIND_WRITE:
            begin
                if (!failed_reg && wpos_reg < count)
                begin
                    res.status    = mtpc_pkg::ST_WRITE;
                    res.address   = cfg.base_address
                                  + mtpc_pkg::ADDR_W'({wpos_reg, 2'b00});
                    res.data_word = wgen_reg;
                    res.last      = (wpos_reg + 1'b1 == count);
                    wpos_next     = wpos_reg + 1'b1;
                    wgen_next     = mtpc_pkg::advance_word(cfg.mode, wgen_reg);
                end
            end
            mtpc_pkg::KIND_CHECK:
            begin
                if (!failed_reg && cpos_reg < count)
                begin
                    res.address     = cfg.base_address
                                    + mtpc_pkg::ADDR_W'({cpos_reg, 2'b00});
                    res.data_word   = cgen_reg;
                    res.actual_word = read_data;
                    res.last        = (cpos_reg + 1'b1 == count);
                    if (read_data == cgen_reg)
                    begin
                        res.status = mtpc_pkg::ST_MATCH;
                        cpos_next  = cpos_reg + 1'b1;
                        cgen_next  = mtpc_pkg::advance_word(cfg.mode, cgen_reg);
                    end
                    else
                    begin
                        res.status  = mtpc_pkg::ST_MISMATCH;
                        failed_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg   <= '0;
            cpos_reg   <= '0;
            wgen_reg   <= mtpc_pkg::SEED_RESET;
            cgen_reg   <= mtpc_pkg::SEED_RESET;
            failed_reg <= 1'b0;
        end
        else if (step)
        begin
            wpos_reg   <= wpos_next;
            cpos_reg   <= cpos_next;
            wgen_reg   <= wgen_next;
            cgen_reg   <= cgen_next;
            failed_reg <= failed_next;
        end
    end

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && kind == mtpc_pkg::KIND_RESTART
        |=> wpos_reg == '0 && cpos_reg == '0 && !failed_reg)
        else $error("restart did not rewind the test state");

    a_mismatch_latches: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.status == mtpc_pkg::ST_MISMATCH
        |=> failed_reg && $stable(cpos_reg) && $stable(cgen_reg))
        else $error("mismatch did not latch failure or moved check position");

    a_failed_ignores: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg && kind != mtpc_pkg::KIND_RESTART
        |-> res.status == mtpc_pkg::ST_IGNORED)
        else $error("item handled after a latched failure");

    a_fixed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg.mode && res.status == mtpc_pkg::ST_WRITE
        |=> $stable(wgen_reg))
        else $error("write generator moved in fixed pattern mode");
`endif

endmodule

>>> sv/memory_test_pattern_checker_top.sv
// Top level of the memory test pattern checker: input register, engine,
// result register and configuration registers. Depends on mtpc_pkg,
// mtpc_cfg_regs and mtpc_engine.
//
// Usage:
//   Input channel (in_valid/in_stall): kind selects write, check or restart;
//   read_data carries the read-back word for checks. Output channel
//   (out_valid/out_stall): one result item per input item, in order:
//   status, address, data_word, actual_word, last.
//   An item taken sits in the input register, is evaluated against the test
//   state and stored in the result register, from which the result is taken.
//   Throughput is one item per cycle while out_stall is low: the generator
//   step (three xorshift rounds) and the compare are one pass of logic
//   between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item; in_stall rises only while both are
//   full and out_stall is high.
//   Reset (rst_n low) empties both registers, rewinds both phases, loads the
//   reset seed into both generators and restores the register reset values.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   a new seed is used from the next restart item.
module memory_test_pattern_checker_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mtpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mtpc_pkg::DATA_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mtpc_pkg::KIND_W-1:0]        kind,
    input  logic [mtpc_pkg::DATA_W-1:0]        read_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [mtpc_pkg::ADDR_W-1:0]        address,
    output logic [mtpc_pkg::DATA_W-1:0]        data_word,
    output logic [mtpc_pkg::DATA_W-1:0]        actual_word,
    output logic                               last
);

    mtpc_pkg::cfg_t                 cfg;
    mtpc_pkg::result_t              eng_res;
    mtpc_pkg::result_t              res_reg;
    logic                           in_valid_reg;
    logic [mtpc_pkg::KIND_W-1:0]    kind_reg;
    logic [mtpc_pkg::DATA_W-1:0]    rdata_reg;
    logic                           out_valid_reg;
    logic                           advance;
    logic                           in_take;

    // The stored item moves on whenever the result register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    mtpc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mtpc_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .kind      (kind_reg),
        .read_data (rdata_reg),
        .cfg       (cfg),
        .res       (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg  <= kind;
            rdata_reg <= read_data;
        end
        if (advance)
            res_reg <= eng_res;
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign address     = res_reg.address;
    assign data_word   = res_reg.data_word;
    assign actual_word = res_reg.actual_word;
    assign last        = res_reg.last;

endmodule

>>> tb/sv/tb_memory_test_pattern_checker_top.sv
// Self-checking testbench for memory_test_pattern_checker_top: bursty item driver,
// stalling result monitor and an item-level model of the pattern engine.
// Depends on mtpc_pkg and the block's RTL.
module tb_memory_test_pattern_checker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mtpc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 63;

    // How the driver fills read_data when it puts a check item on the bus.
    typedef enum logic [1:0] {RD_GOOD, RD_FLIP, RD_RAND, RD_FIXED} rd_pick_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        rd_pick_t          pick;
        logic [DATA_W-1:0] value;
    } access_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    cfg_index_t           cfg_index = REG_MODE;
    logic [DATA_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [KIND_W-1:0]    kind = KIND_WRITE;
    logic [DATA_W-1:0]    read_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [ADDR_W-1:0]    address;
    logic [DATA_W-1:0]    data_word;
    logic [DATA_W-1:0]    actual_word;
    logic                 last;

    memory_test_pattern_checker_top uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .read_data  (read_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .address    (address),
        .data_word  (data_word),
        .actual_word(actual_word),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Engine copy: configuration and test state.
    logic              eng_mode  = 1'b0;
    logic [DATA_W-1:0] eng_seed  = SEED_RESET;
    logic [ADDR_W-1:0] eng_base  = BASE_RESET;
    logic [POS_W-1:0]  eng_count = COUNT_RESET;
    int unsigned       wr_pos    = 0;
    logic [DATA_W-1:0] wr_word   = SEED_RESET;
    int unsigned       ck_pos    = 0;
    logic [DATA_W-1:0] ck_word   = SEED_RESET;
    logic              latched_fail = 1'b0;

    result_t     predicted_reports[$];
    access_t     access_queue[$];
    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned fail_count = 0;
    logic        long_hold  = 1'b0;

    function automatic logic [DATA_W-1:0] next_pattern(input logic shifting,
                                                       input logic [DATA_W-1:0] w);
        logic [DATA_W-1:0] s;
        s = w;
        if (shifting)
        begin
            repeat (3)
            begin
                s ^= s << 13;
                s ^= s >> 17;
                s ^= s << 5;
            end
        end
        return s;
    endfunction

    task automatic step_pattern_engine(input logic [KIND_W-1:0] k,
                                       input logic [DATA_W-1:0] rd);
        result_t     r;
        int unsigned words;
        r = '0;
        r.status = ST_IGNORED;
        words = (eng_count > MAX_WORDS) ? MAX_WORDS : eng_count;
        case (k)
            KIND_RESTART:
            begin
                wr_pos = 0;
                ck_pos = 0;
                wr_word = eng_seed;
                ck_word = eng_seed;
                latched_fail = 1'b0;
            end
            KIND_WRITE:
            begin
                if (!latched_fail && wr_pos < words)
                begin
                    r.status = ST_WRITE;
                    r.address = eng_base + ADDR_W'(wr_pos * 4);
                    r.data_word = wr_word;
                    r.last = (wr_pos + 1 == words);
                    wr_pos++;
                    wr_word = next_pattern(eng_mode, wr_word);
                end
            end
            KIND_CHECK:
            begin
                if (!latched_fail && ck_pos < words)
                begin
                    r.address = eng_base + ADDR_W'(ck_pos * 4);
                    r.data_word = ck_word;
                    r.actual_word = rd;
                    r.last = (ck_pos + 1 == words);
                    if (rd == ck_word)
                    begin
                        r.status = ST_MATCH;
                        ck_pos++;
                        ck_word = next_pattern(eng_mode, ck_word);
                    end
                    else
                    begin
                        // first mismatch: position holds, everything after it up to a restart is ignored
                        r.status = ST_MISMATCH;
                        latched_fail = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        predicted_reports.push_back(r);
    endtask

    function automatic logic [DATA_W-1:0] pick_read_data(input access_t a);
        case (a.pick)
            RD_GOOD: return ck_word;
            RD_FLIP: return ck_word ^ (32'h1 << $urandom_range(0, 31));
            RD_RAND: return $urandom;
            default: return a.value;
        endcase
    endfunction

    // Driver: bursts of items with random gaps; gaps are skipped during the long hold.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        access_t a;
        logic    take;
        logic    v_next;
        int      burst_left;
        int      gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            take = in_valid && !in_stall;
            v_next = in_valid && !take;
            if (take)
            begin
                step_pattern_engine(kind, read_data);
                n_accepted++;
            end
            if (!v_next)
            begin
                if (gap_left > 0 && !long_hold)
                    gap_left--;
                else if (access_queue.size() > 0)
                begin
                    a = access_queue.pop_front();
                    kind <= a.kind;
                    read_data <= pick_read_data(a);
                    v_next = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= v_next;
        end
    end

    // Receiver stall pattern, plus one long hold-off while items keep coming.
    always @(posedge clk or negedge rst_n)
    begin : stall_results
        int          stall_mode;
        int          mode_left;
        int          hold_left;
        logic        hold_done;
        int unsigned tick;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            long_hold <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
            tick = 0;
        end
        else
        begin
            tick++;
            if (!hold_done && n_accepted > 150 && access_queue.size() > 20)
            begin
                hold_done = 1'b1;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
                long_hold <= 1'b1;
            end
            else
            begin
                long_hold <= 1'b0;
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 80);
                end
                else
                    mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (tick % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_reports.size() == 0)
            begin
                $error("result item with nothing pending: status %0d address %h", status, address);
                fail_count++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                if (status !== want.status)
                begin
                    $error("status expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (address !== want.address)
                begin
                    $error("address expected %h, got %h", want.address, address);
                    fail_count++;
                end
                if (data_word !== want.data_word)
                begin
                    $error("data_word expected %h, got %h", want.data_word, data_word);
                    fail_count++;
                end
                if (actual_word !== want.actual_word)
                begin
                    $error("actual_word expected %h, got %h", want.actual_word, actual_word);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last expected %0d, got %0d", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic add_item(input logic [KIND_W-1:0] k, input rd_pick_t p,
                            input logic [DATA_W-1:0] v = '0);
        access_t a;
        a.kind = k;
        a.pick = p;
        a.value = v;
        access_queue.push_back(a);
        n_queued++;
    endtask

    // Only called while the block is idle, so the engine copy can follow at once.
    task automatic write_reg(input cfg_index_t idx, input logic [DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_MODE:  eng_mode = val[0];
            REG_SEED:  eng_seed = val;
            REG_BASE:  eng_base = val;
            default:   eng_count = val[POS_W-1:0];
        endcase
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || predicted_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(input int phase_no);
        logic [DATA_W-1:0] v;
        logic [POS_W-1:0]  words;
        int                r;
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_MODE, {31'($urandom), 1'($urandom_range(0, 1))});
        if ($urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 5);
            v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            write_reg(REG_SEED, v);
        end
        if ($urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 5);
            v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFC : $urandom;
            write_reg(REG_BASE, v);
        end
        r = $urandom_range(0, 9);
        if (phase_no == 0)
            words = '0;
        else if (phase_no == 1)
            words = 23'd1;
        else if (r < 7)
            words = POS_W'($urandom_range(2, 40));
        else if (r == 7)
            words = POS_W'(MAX_WORDS);
        else if (r == 8)
            words = '1;
        else
            words = POS_W'($urandom);
        write_reg(REG_COUNT, {9'($urandom), words});
        cfg_we <= 1'b0;
        @(posedge clk);

        add_item(KIND_RESTART, RD_RAND);
        repeat (PHASE_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 42)
                add_item(KIND_WRITE, RD_RAND);
            else if (r < 80)
                add_item(KIND_CHECK, RD_GOOD);
            else if (r < 85)
                add_item(KIND_CHECK, RD_FLIP);
            else if (r < 89)
                add_item(KIND_CHECK, RD_RAND);
            else if (r < 94)
                add_item(KIND_RESTART, RD_RAND);
            else
                add_item(KIND_UNUSED, RD_RAND);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: fixed pattern, mismatch latches until restart.
        add_item(KIND_WRITE, RD_RAND);
        add_item(KIND_CHECK, RD_GOOD);
        add_item(KIND_CHECK, RD_FLIP);
        add_item(KIND_WRITE, RD_RAND);
        add_item(KIND_CHECK, RD_GOOD);
        add_item(KIND_UNUSED, RD_FIXED, 32'hFFFF_FFFF);
        add_item(KIND_RESTART, RD_FIXED, 32'h0);
        add_item(KIND_WRITE, RD_RAND);
        add_item(KIND_CHECK, RD_GOOD);
        add_item(KIND_CHECK, RD_FIXED, 32'h0);
        add_item(KIND_RESTART, RD_RAND);
        wait_drained();

        // Xorshift, three words at the top of the address space: wrap and phase end.
        write_reg(REG_MODE, 32'hFFFF_FFFF);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        write_reg(REG_BASE, 32'hFFFF_FFF8);
        write_reg(REG_COUNT, 32'h0000_0003);
        cfg_we <= 1'b0;
        @(posedge clk);
        add_item(KIND_RESTART, RD_RAND);
        repeat (4) add_item(KIND_WRITE, RD_RAND);
        repeat (3) add_item(KIND_CHECK, RD_GOOD);
        add_item(KIND_CHECK, RD_GOOD);
        wait_drained();

        // New seed waits for restart; count saturates; fixed mode mid-phase.
        write_reg(REG_SEED, 32'h0000_0000);
        write_reg(REG_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_MODE, 32'hFFFF_FFFE);
        cfg_we <= 1'b0;
        @(posedge clk);
        add_item(KIND_WRITE, RD_RAND);
        add_item(KIND_CHECK, RD_GOOD);
        add_item(KIND_RESTART, RD_RAND);
        add_item(KIND_WRITE, RD_RAND);
        add_item(KIND_CHECK, RD_FIXED, 32'hFFFF_FFFF);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(p);

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/mtpc_pkg.sv
sv/mtpc_cfg_regs.sv
sv/mtpc_engine.sv
sv/memory_test_pattern_checker_top.sv
tb/sv/tb_memory_test_pattern_checker_top.sv
